>>> rtl/first_repeated_element_finder_defines.svh
// Assertion macros shared by the first repeated element finder RTL.
// Each macro expects clk and the active-low reset rst_n in the enclosing module.
`ifndef FIRST_REPEATED_ELEMENT_FINDER_DEFINES_SVH
`define FIRST_REPEATED_ELEMENT_FINDER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FRF_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define FRF_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the next cycle.
`define FRF_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/frf_pkg.sv
// Package for the first repeated element finder: sizes and the token type.
// Used by the intake, the cells and the top level; depends on nothing.
`timescale 1ns / 1ps

package frf_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 11;
  localparam int POS_W      = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  // A token travels one cell per cycle. It may carry an element that still
  // looks for its place, the end-of-sequence scan, or both.
  typedef struct packed {
    logic               item;
    logic               last;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               found;
    logic [POS_W-1:0]   fpos;
    logic               ovf;
  } frf_tok_t;

endpackage

>>> rtl/frf_intake.sv
// Input side of the finder: accepts transactions, numbers the elements and
// tracks overflow, then forms the token for the first cell. Uses frf_pkg.
`timescale 1ns / 1ps
`include "first_repeated_element_finder_defines.svh"

module frf_intake
  import frf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  output frf_tok_t           tok_o
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             acc;
  logic             full;
  logic             take_item;

  assign busy      = !rst_n;
  assign acc       = start && rst_n;
  assign full      = (cnt_r == CNT_W'(MAX_ITEMS));
  assign take_item = acc && !full;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (acc && in_last) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    tok_o       = '0;
    tok_o.item  = take_item;
    tok_o.last  = acc && in_last;
    tok_o.value = in_value;
    tok_o.pos   = cnt_r[POS_W-1:0];
    tok_o.ovf   = ovf_r || (acc && full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  `FRF_CHECK(a_cnt_bound, cnt_r <= CNT_W'(MAX_ITEMS), "element count beyond limit")
  `FRF_NEXT(a_ovf_needs_full, acc && !in_last && !ovf_r && ovf_nxt, full == 1'b1, "overflow early")

endmodule

>>> rtl/frf_cell.sv
// One table cell: holds a distinct value, its first position and a repeat
// mark, and passes the token on to the next cell. Uses frf_pkg.
`timescale 1ns / 1ps
`include "first_repeated_element_finder_defines.svh"

module frf_cell
  import frf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  frf_tok_t tok_i,
  output frf_tok_t tok_o
);

  frf_tok_t           tok_r, tok_nxt;
  logic               vld_r, vld_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]   fpos_r, fpos_nxt;
  logic               mark_r, mark_nxt;
  logic               hit, take;
  logic               vld_now;

  assign hit     = tok_i.item && vld_r && (val_r == tok_i.value);
  assign take    = tok_i.item && !vld_r;
  assign vld_now = vld_r || take;

  always_comb begin
    val_nxt  = take ? tok_i.value : val_r;
    fpos_nxt = take ? tok_i.pos : fpos_r;
    mark_nxt = hit || (mark_r && !take);
    vld_nxt  = vld_now;
    tok_nxt      = tok_i;
    tok_nxt.item = tok_i.item && !hit && !take;
    // The scan picks up the first marked entry, seeing this cycle's update,
    // and empties the cell behind it.
    if (tok_i.last) begin
      if (!tok_i.found && vld_now && mark_nxt) begin
        tok_nxt.found = 1'b1;
        tok_nxt.fpos  = fpos_nxt;
      end
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      tok_r.item <= 1'b0;
      tok_r.last <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      tok_r.item <= tok_nxt.item;
      tok_r.last <= tok_nxt.last;
    end
    val_r       <= val_nxt;
    fpos_r      <= fpos_nxt;
    mark_r      <= mark_nxt;
    tok_r.value <= tok_nxt.value;
    tok_r.pos   <= tok_nxt.pos;
    tok_r.found <= tok_nxt.found;
    tok_r.fpos  <= tok_nxt.fpos;
    tok_r.ovf   <= tok_nxt.ovf;
  end

  assign tok_o = tok_r;

  `FRF_NEXT(a_scan_clears, tok_i.last, !vld_r, "cell not emptied by scan")
  `FRF_NEXT(a_hit_marks, hit && !tok_i.last, mark_r && vld_r, "repeat not marked")

endmodule

>>> rtl/first_repeated_element_finder.sv
// First repeated element finder: accepts one element per cycle (busy is low
// whenever the block is out of reset) and reports, for each sequence, one
// transaction on out_strobe once the token of the element flagged last has
// walked the whole cell chain, registered in every cell on its way. The result
// cannot be stalled, and a new sequence may start in the cycle after the last
// element of the previous one.
// Depends on frf_pkg, frf_intake and frf_cell.
`timescale 1ns / 1ps
`include "first_repeated_element_finder_defines.svh"

module first_repeated_element_finder
  import frf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic                  in_last,
  output logic                  out_strobe,
  output logic                  out_found,
  output logic [POSITION_W-1:0] out_position,
  output logic                  out_overflow
);

  frf_tok_t tok_chain [0:MAX_ITEMS];
  frf_tok_t chain_end;

  frf_intake u_intake (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .in_last  (in_last),
    .tok_o    (tok_chain[0])
  );

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    frf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_chain[g]),
      .tok_o (tok_chain[g+1])
    );
  end

  assign chain_end    = tok_chain[MAX_ITEMS];
  assign out_strobe   = chain_end.last;
  assign out_found    = chain_end.found;
  assign out_position = chain_end.found ?
                        POSITION_W'(chain_end.fpos) + POSITION_W'(1) : '0;
  assign out_overflow = chain_end.ovf;

  `FRF_CHECK(a_no_lost_item, !chain_end.item, "element left the chain unplaced")
  `FRF_IMPLIES(a_pos_found, out_strobe && out_found, out_position != '0, "zero position")
  `FRF_IMPLIES(a_pos_none, out_strobe && !out_found, out_position == '0, "stray position")

endmodule
